// File: sv/lsts_pkg.sv
// Shared types, constants and helpers for the least slack time scheduler.
package lsts_pkg;

  localparam int MAX_TASKS = 32;
  localparam int TASK_W    = $clog2(MAX_TASKS);
  localparam int COUNT_W   = 6;
  localparam int TIME_W    = 12;
  localparam int PHASE_W   = 11;
  localparam int SLACK_W   = 14;
  localparam int TOTAL_W   = 32;

  localparam logic [TIME_W-1:0]  TIME_LIMIT = 12'd2048;
  localparam logic [COUNT_W-1:0] IDLE_CODE  = 6'd32;
  localparam logic [COUNT_W-1:0] TASKS_MAX  = 6'd32;

  // result status codes
  localparam logic [1:0] ST_TICK     = 2'd0;
  localparam logic [1:0] ST_LOAD_OK  = 2'd1;
  localparam logic [1:0] ST_LOAD_BAD = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic capture;     // latch the input item
    logic load;        // apply a load item
    logic tick_start;  // clear scan index and best candidate
    logic scan_issue;  // read the entry at the scan index
    logic finish;      // retire the tick: run chosen task, update totals
    logic emit;        // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic op_tick;
    logic n_zero;
    logic scan_last;
    logic out_free;
  } sts_t;

  function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
    sat_inc = (v == {TOTAL_W{1'b1}}) ? v : v + {{(TOTAL_W-1){1'b0}}, 1'b1};
  endfunction

  function automatic logic in_range(input logic [TIME_W-1:0] v);
    in_range = (v != '0) && (v <= TIME_LIMIT);
  endfunction

endpackage

// File: sv/lsts_ctrl.sv
// Sequencer for load and tick items of the least slack time scheduler.
module lsts_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lsts_pkg::sts_t     sts,
  output lsts_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_LOAD,
    S_START,
    S_SCAN,
    S_DRAIN,
    S_FINISH,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_valid) state_next = S_DISPATCH;
      S_DISPATCH: state_next = sts.op_tick ? S_START : S_LOAD;
      S_LOAD:     state_next = S_RESULT;
      S_START:    state_next = sts.n_zero ? S_FINISH : S_SCAN;
      S_SCAN:     if (sts.scan_last) state_next = S_DRAIN;
      S_DRAIN:    state_next = S_FINISH;
      S_FINISH:   state_next = S_RESULT;
      S_RESULT:   if (sts.out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.capture    = (state == S_IDLE) && in_valid;
    cmd.load       = (state == S_LOAD);
    cmd.tick_start = (state == S_START);
    cmd.scan_issue = (state == S_SCAN);
    cmd.finish     = (state == S_FINISH);
    cmd.emit       = (state == S_RESULT) && sts.out_free;
  end

endmodule

// File: sv/lsts_dp.sv
// Task tables, slack compare pass, switch totals and output register.
module lsts_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lsts_pkg::COUNT_W-1:0]      cfg_wdata,
  input  logic                              operation,
  input  logic [lsts_pkg::TASK_W-1:0]       task_index,
  input  logic [lsts_pkg::TIME_W-1:0]       job_length,
  input  logic [lsts_pkg::TIME_W-1:0]       task_period,
  input  logic [lsts_pkg::TIME_W-1:0]       relative_deadline,
  input  lsts_pkg::cmd_t                    cmd,
  output lsts_pkg::sts_t                    sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic [lsts_pkg::COUNT_W-1:0]      chosen_task,
  output logic                              ran_late,
  output logic [lsts_pkg::TOTAL_W-1:0]      context_switches,
  output logic [lsts_pkg::TOTAL_W-1:0]      preemptions
);

  localparam int N = lsts_pkg::MAX_TASKS;
  localparam int AW = lsts_pkg::TASK_W;
  localparam int CW = lsts_pkg::COUNT_W;
  localparam int TW = lsts_pkg::TIME_W;
  localparam int PW = lsts_pkg::PHASE_W;
  localparam int SW = lsts_pkg::SLACK_W;
  localparam int XW = lsts_pkg::TOTAL_W;

  // configuration
  logic [CW-1:0] task_count;
  logic [CW-1:0] n_eff;

  // captured input item
  logic          op_q;
  logic [AW-1:0] idx_q;
  logic [TW-1:0] len_in_q;
  logic [TW-1:0] per_in_q;
  logic [TW-1:0] dl_in_q;
  logic          load_ok;

  // task storage
  logic [TW-1:0] length_mem   [N];
  logic [TW-1:0] period_mem   [N];
  logic [TW-1:0] deadline_mem [N];
  logic [TW-1:0] rem_mem      [N];
  logic [PW-1:0] phase_mem    [N];
  logic [N-1:0]  rem_vld;
  logic [N-1:0]  ph_vld;

  // scan pipeline
  logic [CW-1:0] cnt;
  logic [TW-1:0] len_q;
  logic [TW-1:0] per_q;
  logic [TW-1:0] dl_q;
  logic [TW-1:0] rem_q;
  logic [PW-1:0] ph_q;
  logic          remv_q;
  logic          phv_q;
  logic          s1_valid;
  logic [AW-1:0] s1_idx;

  logic [PW-1:0]        ph_rd;
  logic [TW-1:0]        rem_rd;
  logic [TW-1:0]        rem_new;
  logic [TW-1:0]        ph_inc;
  logic [PW-1:0]        ph_new;
  logic signed [SW-1:0] slack;
  logic                 take;

  // best candidate
  logic                 found;
  logic signed [SW-1:0] best_slack;
  logic [AW-1:0]        best_idx;
  logic [PW-1:0]        best_ph;
  logic [TW-1:0]        best_dl;
  logic [TW-1:0]        best_rem;

  // run state and totals
  logic [CW-1:0] last_run;
  logic          was_interrupted;
  logic [XW-1:0] switch_total;
  logic [XW-1:0] preempt_total;

  logic [TW-1:0] rem_after;
  logic          late_f;
  logic [CW-1:0] chosen_f;
  logic [XW-1:0] sw_mid;
  logic [XW-1:0] sw_n;
  logic [XW-1:0] pr_n;
  logic          wi_n;
  logic [CW-1:0] last_n;

  // held result
  logic [1:0]    res_status;
  logic [CW-1:0] res_chosen;
  logic          res_late;

  logic          rem_we;
  logic [AW-1:0] rem_wa;
  logic [TW-1:0] rem_wd;

  assign n_eff   = (task_count > lsts_pkg::TASKS_MAX) ? lsts_pkg::TASKS_MAX : task_count;
  assign load_ok = lsts_pkg::in_range(len_in_q) && lsts_pkg::in_range(per_in_q)
                   && lsts_pkg::in_range(dl_in_q);

  assign sts.op_tick   = (op_q == lsts_pkg::OP_TICK);
  assign sts.n_zero    = (n_eff == '0);
  assign sts.scan_last = ((cnt + {{(CW-1){1'b0}}, 1'b1}) == n_eff);
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= {{(CW-1){1'b0}}, 1'b1};
    end else if (cfg_we) begin
      task_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q     <= operation;
      idx_q    <= task_index;
      len_in_q <= job_length;
      per_in_q <= task_period;
      dl_in_q  <= relative_deadline;
    end
  end

  // parameter tables: written by loads, read at the scan index
  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      length_mem[idx_q]   <= len_in_q;
      period_mem[idx_q]   <= per_in_q;
      deadline_mem[idx_q] <= dl_in_q;
    end
    len_q <= length_mem[cnt[AW-1:0]];
    per_q <= period_mem[cnt[AW-1:0]];
    dl_q  <= deadline_mem[cnt[AW-1:0]];
  end

  // remaining work: scan reload, then one decrement for the chosen task
  assign rem_after = best_rem - {{(TW-1){1'b0}}, 1'b1};
  assign rem_we    = s1_valid || (cmd.finish && found);
  assign rem_wa    = s1_valid ? s1_idx : best_idx;
  assign rem_wd    = s1_valid ? rem_new : rem_after;

  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_mem[rem_wa] <= rem_wd;
    end
    rem_q <= rem_mem[cnt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      phase_mem[s1_idx] <= ph_new;
    end
    ph_q <= phase_mem[cnt[AW-1:0]];
  end

  // an entry with a clear valid bit reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      rem_vld <= '0;
      ph_vld  <= '0;
    end else if (cmd.load && load_ok) begin
      rem_vld[idx_q] <= 1'b0;
      ph_vld[idx_q]  <= 1'b0;
    end else if (s1_valid) begin
      rem_vld[s1_idx] <= 1'b1;
      ph_vld[s1_idx]  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    remv_q <= rem_vld[cnt[AW-1:0]];
    phv_q  <= ph_vld[cnt[AW-1:0]];
    s1_idx <= cnt[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      cnt      <= '0;
    end else begin
      s1_valid <= cmd.scan_issue;
      if (cmd.tick_start) begin
        cnt <= '0;
      end else if (cmd.scan_issue) begin
        cnt <= cnt + {{(CW-1){1'b0}}, 1'b1};
      end
    end
  end

  // compare stage
  assign ph_rd   = phv_q ? ph_q : '0;
  assign rem_rd  = remv_q ? rem_q : '0;
  assign rem_new = (ph_rd == '0) ? len_q : rem_rd;
  assign ph_inc  = {{(TW-PW){1'b0}}, ph_rd} + {{(TW-1){1'b0}}, 1'b1};
  assign ph_new  = (ph_inc >= per_q) ? '0 : ph_inc[PW-1:0];
  assign slack   = $signed({{(SW-TW){1'b0}}, dl_q})
                   - $signed({{(SW-PW){1'b0}}, ph_rd})
                   - $signed({{(SW-TW){1'b0}}, rem_new});
  assign take    = s1_valid && (rem_new != '0) && (!found || (slack < best_slack));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.tick_start) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_slack <= slack;
      best_idx   <= s1_idx;
      best_ph    <= ph_rd;
      best_dl    <= dl_q;
      best_rem   <= rem_new;
    end
  end

  // tick retirement
  assign late_f   = found && ({{(TW-PW){1'b0}}, best_ph} >= best_dl);
  assign chosen_f = found ? {{(CW-AW){1'b0}}, best_idx} : lsts_pkg::IDLE_CODE;

  always_comb begin
    sw_mid = switch_total;
    sw_n   = switch_total;
    pr_n   = preempt_total;
    wi_n   = was_interrupted;
    last_n = chosen_f;
    if (found) begin
      if (last_run != chosen_f) begin
        if (was_interrupted) begin
          sw_mid = lsts_pkg::sat_inc(switch_total);
          pr_n   = lsts_pkg::sat_inc(preempt_total);
        end
      end
      if (rem_after == '0) begin
        sw_n = lsts_pkg::sat_inc(sw_mid);
        wi_n = 1'b0;
      end else begin
        sw_n = sw_mid;
        wi_n = 1'b1;
      end
    end else begin
      // idle right after a running tick counts as a switch away and a preemption
      if (last_run != lsts_pkg::IDLE_CODE) begin
        sw_n = lsts_pkg::sat_inc(switch_total);
        pr_n = lsts_pkg::sat_inc(preempt_total);
      end
      wi_n = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_run        <= lsts_pkg::IDLE_CODE;
      was_interrupted <= 1'b0;
      switch_total    <= '0;
      preempt_total   <= '0;
    end else if (cmd.finish) begin
      last_run        <= last_n;
      was_interrupted <= wi_n;
      switch_total    <= sw_n;
      preempt_total   <= pr_n;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_status <= load_ok ? lsts_pkg::ST_LOAD_OK : lsts_pkg::ST_LOAD_BAD;
      res_chosen <= lsts_pkg::IDLE_CODE;
      res_late   <= 1'b0;
    end else if (cmd.finish) begin
      res_status <= lsts_pkg::ST_TICK;
      res_chosen <= chosen_f;
      res_late   <= late_f;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status           <= res_status;
      chosen_task      <= res_chosen;
      ran_late         <= res_late;
      context_switches <= switch_total;
      preemptions      <= preempt_total;
    end
  end

endmodule

// File: sv/least_slack_time_scheduler.sv
// Top level of the least slack time periodic task scheduler.
// Input channel (in_valid/in_ready) takes one item: a load of one task entry
// (job_length, task_period, relative_deadline at task_index) or a time tick.
// Output channel (out_valid/out_ready) returns one result per item: status,
// chosen_task (32 = idle), ran_late and the saturating switch and preemption
// totals. cfg_we/cfg_wdata write task_count; the user must write it only
// while the block is idle, which the block does not enforce. A load goes
// from dispatch through load to result; a tick goes through dispatch, start,
// a scan of n = min(task_count, 32) entries, drain and finish (start skips
// to finish if n is 0). The compare pass reads one task entry per cycle and
// updates it in the next cycle. One item is in work at a time; in_ready is
// high only between items. If out_ready is low, a finished result waits in
// the output register and the next item's result in the held registers.
// Reset (rst, synchronous) sets task_count to 1, clears remaining work and
// phase of every task, last run to idle and both totals to zero. Task tables
// are undefined until loaded.
module least_slack_time_scheduler (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lsts_pkg::COUNT_W-1:0]      cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              operation,
  input  logic [lsts_pkg::TASK_W-1:0]       task_index,
  input  logic [lsts_pkg::TIME_W-1:0]       job_length,
  input  logic [lsts_pkg::TIME_W-1:0]       task_period,
  input  logic [lsts_pkg::TIME_W-1:0]       relative_deadline,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic [lsts_pkg::COUNT_W-1:0]      chosen_task,
  output logic                              ran_late,
  output logic [lsts_pkg::TOTAL_W-1:0]      context_switches,
  output logic [lsts_pkg::TOTAL_W-1:0]      preemptions
);

  lsts_pkg::cmd_t cmd;
  lsts_pkg::sts_t sts;

  lsts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lsts_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .operation         (operation),
    .task_index        (task_index),
    .job_length        (job_length),
    .task_period       (task_period),
    .relative_deadline (relative_deadline),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .chosen_task       (chosen_task),
    .ran_late          (ran_late),
    .context_switches  (context_switches),
    .preemptions       (preemptions)
  );

endmodule
